FILE: rtl/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce, long-press and repeat block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    // Key count and field widths
    localparam int NUM_KEYS    = 6;
    localparam int STAMP_W     = 32;
    localparam int TIME_W      = 16;
    localparam int MODE_W      = 2;
    localparam int EVENT_W     = 3;
    localparam int CFG_IDX_W   = 2;

    // Key modes
    localparam logic [MODE_W-1:0] MODE_RELEASED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRESSED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LONG     = 2'd2;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LONG    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] FILTER_RST = 16'd50;
    localparam logic [TIME_W-1:0] LONG_RST   = 16'd1000;
    localparam logic [TIME_W-1:0] REPEAT_RST = 16'd200;

    // Input request: one polling tick
    typedef struct packed {
        logic [STAMP_W-1:0]  now_ms;
        logic [NUM_KEYS-1:0] pin_levels;
        logic [NUM_KEYS-1:0] clear_mask;
    } t_in_req;

    // Result request: packed states and latched events
    typedef struct packed {
        logic [MODE_W*NUM_KEYS-1:0]  key_states;
        logic [EVENT_W*NUM_KEYS-1:0] key_events;
    } t_out_req;

    // Timing settings handed to every key cell
    typedef struct packed {
        logic [TIME_W-1:0] filter_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] repeat_ms;
    } t_cfg;

endpackage

FILE: rtl/kdlp_cfg.sv
// ----------------------------------------------------------------------------
// kdlp_cfg
// Timing register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module kdlp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdlp_pkg::TIME_W-1:0]    i_cfg_wdata,
    output kdlp_pkg::t_cfg                 o_cfg
);
    import kdlp_pkg::*;

    t_cfg r_cfg;

    // Decode the write; unused index drops the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_ms     <= FILTER_RST;
            r_cfg.long_press_ms <= LONG_RST;
            r_cfg.repeat_ms     <= REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER: r_cfg.filter_ms     <= i_cfg_wdata;
                CFG_LONG:   r_cfg.long_press_ms <= i_cfg_wdata;
                CFG_REPEAT: r_cfg.repeat_ms     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/kdlp_key.sv
// ----------------------------------------------------------------------------
// kdlp_key
// Per-key debounce cell: stable level, mode, latched event and time stamps.
// ----------------------------------------------------------------------------
module kdlp_key (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [kdlp_pkg::STAMP_W-1:0]  i_now,
    input  logic                          i_level,
    input  logic                          i_clear,
    input  kdlp_pkg::t_cfg                i_cfg,
    output logic [kdlp_pkg::MODE_W-1:0]   o_mode_next,
    output logic [kdlp_pkg::EVENT_W-1:0]  o_event_next
);
    import kdlp_pkg::*;

    logic                r_level;
    logic [MODE_W-1:0]   r_mode;
    logic [EVENT_W-1:0]  r_event;
    logic [STAMP_W-1:0]  r_press;
    logic [STAMP_W-1:0]  r_last;

    logic                n_level;
    logic [MODE_W-1:0]   n_mode;
    logic [EVENT_W-1:0]  n_event;
    logic [STAMP_W-1:0]  n_press;
    logic [STAMP_W-1:0]  n_last;

    logic [STAMP_W-1:0]  w_since_last;
    logic [STAMP_W-1:0]  w_since_press;
    logic                w_filter_ok;
    logic                w_long_ok;
    logic                w_repeat_ok;

    // Elapsed times, modulo 2^32
    assign w_since_last  = i_now - r_last;
    assign w_since_press = i_now - r_press;
    assign w_filter_ok   = w_since_last  >= {{(STAMP_W-TIME_W){1'b0}}, i_cfg.filter_ms};
    assign w_long_ok     = w_since_press >= {{(STAMP_W-TIME_W){1'b0}}, i_cfg.long_press_ms};
    assign w_repeat_ok   = w_since_last  >= {{(STAMP_W-TIME_W){1'b0}}, i_cfg.repeat_ms};

    // Clear the pending event, then debounce and time the hold
    always_comb begin
        n_level = r_level;
        n_mode  = r_mode;
        n_event = i_clear ? EV_NONE : r_event;
        n_press = r_press;
        n_last  = r_last;
        if (i_level != r_level) begin
            if (w_filter_ok) begin
                n_level = i_level;
                n_last  = i_now;
                if (!i_level) begin
                    if (r_mode == MODE_RELEASED) begin
                        n_mode  = MODE_PRESSED;
                        n_event = EV_PRESS;
                        n_press = i_now;
                    end
                end else if (r_mode != MODE_RELEASED) begin
                    n_mode  = MODE_RELEASED;
                    n_event = EV_RELEASE;
                end
            end
        end else if (r_mode == MODE_PRESSED) begin
            if (w_long_ok) begin
                n_mode  = MODE_LONG;
                n_event = EV_LONG;
                n_last  = i_now;
            end
        end else if (r_mode == MODE_LONG) begin
            if (w_repeat_ok) begin
                n_event = EV_REPEAT;
                n_last  = i_now;
            end
        end
    end

    // Commit the key state when a request is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_mode  <= MODE_RELEASED;
            r_event <= EV_NONE;
            r_press <= '0;
            r_last  <= '0;
        end else if (i_adv) begin
            r_level <= n_level;
            r_mode  <= n_mode;
            r_event <= n_event;
            r_press <= n_press;
            r_last  <= n_last;
        end
    end

    assign o_mode_next  = n_mode;
    assign o_event_next = n_event;

    // A held key always sits at the low stable level
    a_held_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_RELEASED) |-> !r_level)
        else $error("kdlp_key: key held while stable level is high");

    // Long and repeat events only stand while the key is in long press
    a_long_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_event == EV_LONG || r_event == EV_REPEAT) |-> (r_mode == MODE_LONG))
        else $error("kdlp_key: long or repeat event outside long press");

    // A press event stands only while the key is pressed
    a_press_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_event == EV_PRESS) |-> (r_mode == MODE_PRESSED))
        else $error("kdlp_key: press event outside pressed mode");

    // Idle cycles leave the key state alone
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_adv && $past(i_rst_n)) |=> ($stable(r_mode) && $stable(r_event)))
        else $error("kdlp_key: key state moved without a request");

endmodule

FILE: rtl/key_debounce_long_press_repeat.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_repeat
// Debounce for a bank of keys with press, release, long-press and repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req): one request per polling
//   tick with the millisecond time stamp, the raw pin levels (high = released)
//   and a mask of pending events to clear before the tick is processed.
//   Output channel (o_out_valid / i_out_stall / o_out_req): one result per
//   request with the two-bit mode and three-bit latched event of every key.
//   Timing registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata;
//   the user must write them only while no request is in flight, and the block
//   itself has no check for it. A request is captured in the input register,
//   then processed by all key cells in parallel as the result register takes
//   it and offers its result. Throughput is one request per cycle unless the
//   receiver stalls, set by the single combinational pass between the registers.
//   Reset (synchronous, active low) restores the timing defaults, puts every
//   key in the released state with no event and drops both registers.
//   When the receiver stalls, the result holds; the input register still
//   takes one more request and then stalls the sender.
// ----------------------------------------------------------------------------
module key_debounce_long_press_repeat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  kdlp_pkg::t_in_req              i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output kdlp_pkg::t_out_req             o_out_req,
    input  logic                           i_cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kdlp_pkg::TIME_W-1:0]    i_cfg_wdata
);
    import kdlp_pkg::*;

    logic               r_in_valid;
    t_in_req            r_in;
    logic               r_out_valid;
    t_out_req           r_out;
    t_out_req           n_out;

    t_cfg               w_cfg;
    logic               w_out_free;
    logic               w_adv;
    logic               w_take;
    logic [MODE_W-1:0]  w_mode  [NUM_KEYS];
    logic [EVENT_W-1:0] w_event [NUM_KEYS];

    // Handshake control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_take     = i_in_valid && !o_in_stall;

    // Timing registers
    kdlp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // One debounce cell per key
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
        kdlp_key u_key (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_now        (r_in.now_ms),
            .i_level      (r_in.pin_levels[g]),
            .i_clear      (r_in.clear_mask[g]),
            .i_cfg        (w_cfg),
            .o_mode_next  (w_mode[g]),
            .o_event_next (w_event[g])
        );
    end

    // Pack the updated key states into the result
    always_comb begin
        n_out = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_out.key_states[MODE_W*k +: MODE_W]   = w_mode[k];
            n_out.key_events[EVENT_W*k +: EVENT_W] = w_event[k];
        end
    end

    // Input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (w_take) begin
            r_in <= i_in_req;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // Stall the sender only while a request is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("top: input stalled with an empty input register");

    // A processed request always shows up as a result
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("top: processed request produced no result");

    // A stalled result keeps its register occupied
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("top: stalled result was dropped");

endmodule
